@@ sv/fpsa_pkg.sv @@
// fpsa_pkg: shared types, constants and helper for the fixed pool slot allocator
// no dependencies; used by fixed_pool_slot_allocator, fpsa_ram and the testbench
package fpsa_pkg;

  localparam int POOL_SIZE_DEF = 16;
  localparam int WORD_W        = 16;
  localparam int BIT_W         = 4;
  localparam int IDX_W         = 8;
  localparam int KIND_W        = 1;
  localparam int GRANT_W       = 7;
  localparam int STATUS_W      = 2;
  localparam int CNT_W         = 8;
  localparam int OUT_DATA_W    = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_EMPTY        = 2'd1,
    ST_INVALID      = 2'd2,
    ST_ALREADY_FREE = 2'd3
  } status_t;

  // lowest set bit of a free-map word
  function automatic logic [BIT_W-1:0] lowest_one(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        pos = BIT_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

@@ sv/fpsa_ram.sv @@
// fpsa_ram: generic simple dual-port ram, one write and one registered read port
// default width taken from fpsa_pkg
module fpsa_ram #(
  parameter int WIDTH = fpsa_pkg::WORD_W,
  parameter int DEPTH = 1,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/fixed_pool_slot_allocator.sv @@
// fixed_pool_slot_allocator: bitmap free-slot allocator over a pool of slots
// steps: idle takes a request and reads its free-map word, modify updates and writes the word,
//   output loads the result register once free; pool empty or invalid index go from idle to output
// throughput: one item at a time, set by the read-modify-write of one free-map word through
//   the registered-read ram; reset: synchronous, active low; rows read as their reset contents
//   until first written, so no clearing pass; depends on fpsa_pkg and fpsa_ram
module fixed_pool_slot_allocator #(
  parameter int POOL_SIZE = fpsa_pkg::POOL_SIZE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [fpsa_pkg::IDX_W-1:0]      in_tdata,   // [7:0] slot_index
  input  logic [fpsa_pkg::KIND_W-1:0]     in_tuser,   // [0] kind
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [fpsa_pkg::OUT_DATA_W-1:0] out_tdata,  // [6:0] granted_index, [14:7] free_slots
  output logic [fpsa_pkg::STATUS_W-1:0]   out_tuser   // [1:0] status
);
  import fpsa_pkg::*;

  localparam int NWORDS  = (POOL_SIZE + WORD_W - 1) / WORD_W;
  localparam int WADDR_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MOD  = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  kind_t                  kind_r, kind_nxt;
  logic [WADDR_W-1:0]     addr_r, addr_nxt;
  logic [BIT_W-1:0]       bit_r, bit_nxt;
  logic [CNT_W-1:0]       free_cnt_r, free_cnt_nxt;
  logic [NWORDS-1:0]      row_valid_r, row_valid_nxt;
  logic [NWORDS-1:0]      avail_r, avail_nxt;
  logic [GRANT_W-1:0]     res_grant_r, res_grant_nxt;
  status_t                res_status_r, res_status_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [GRANT_W-1:0]     out_grant_r, out_grant_nxt;
  status_t                out_status_r, out_status_nxt;
  logic [CNT_W-1:0]       out_free_r, out_free_nxt;

  logic                   ram_we, ram_re;
  logic [WADDR_W-1:0]     ram_raddr;
  logic [WORD_W-1:0]      ram_wdata, ram_rdata;
  logic [WORD_W-1:0]      init_word, word_cur;
  logic [BIT_W-1:0]       alloc_bit;

  function automatic logic [WADDR_W-1:0] first_row(input logic [NWORDS-1:0] v);
    logic [WADDR_W-1:0] r;
    r = '0;
    for (int i = NWORDS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = WADDR_W'(i);
      end
    end
    return r;
  endfunction

  fpsa_ram #(
    .WIDTH(WORD_W),
    .DEPTH(NWORDS),
    .AW   (WADDR_W)
  ) u_free_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(addr_r),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // reset contents of a row: slots inside the pool are free
  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      init_word[i] = ((int'(addr_r) * WORD_W + i) < POOL_SIZE);
    end
  end

  assign word_cur  = row_valid_r[addr_r] ? ram_rdata : init_word;
  assign alloc_bit = lowest_one(word_cur);
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    addr_nxt       = addr_r;
    bit_nxt        = bit_r;
    free_cnt_nxt   = free_cnt_r;
    row_valid_nxt  = row_valid_r;
    avail_nxt      = avail_r;
    res_grant_nxt  = res_grant_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_grant_nxt  = out_grant_r;
    out_status_nxt = out_status_r;
    out_free_nxt   = out_free_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_raddr      = addr_r;
    ram_wdata      = word_cur;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          kind_nxt      = kind_t'(in_tuser);
          bit_nxt       = in_tdata[BIT_W-1:0];
          res_grant_nxt = '0;
          if (kind_t'(in_tuser) == KIND_ALLOC) begin
            if (avail_r == '0) begin
              res_status_nxt = ST_EMPTY;
              state_nxt      = S_OUT;
            end else begin
              addr_nxt  = first_row(avail_r);
              ram_re    = 1'b1;
              ram_raddr = first_row(avail_r);
              state_nxt = S_MOD;
            end
          end else if (in_tdata >= IDX_W'(POOL_SIZE)) begin
            res_status_nxt = ST_INVALID;
            state_nxt      = S_OUT;
          end else begin
            addr_nxt  = WADDR_W'(in_tdata >> BIT_W);
            ram_re    = 1'b1;
            ram_raddr = WADDR_W'(in_tdata >> BIT_W);
            state_nxt = S_MOD;
          end
        end
      end
      S_MOD: begin
        state_nxt = S_OUT;
        if (kind_r == KIND_ALLOC) begin
          ram_wdata              = word_cur & ~(WORD_W'(1) << alloc_bit);
          ram_we                 = 1'b1;
          row_valid_nxt[addr_r]  = 1'b1;
          avail_nxt[addr_r]      = |(word_cur & ~(WORD_W'(1) << alloc_bit));
          free_cnt_nxt           = free_cnt_r - CNT_W'(1);
          res_grant_nxt          = GRANT_W'({addr_r, alloc_bit});
          res_status_nxt         = ST_OK;
        end else if (word_cur[bit_r]) begin
          res_status_nxt = ST_ALREADY_FREE;
        end else begin
          ram_wdata             = word_cur | (WORD_W'(1) << bit_r);
          ram_we                = 1'b1;
          row_valid_nxt[addr_r] = 1'b1;
          avail_nxt[addr_r]     = 1'b1;
          free_cnt_nxt          = free_cnt_r + CNT_W'(1);
          res_status_nxt        = ST_OK;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_grant_nxt  = res_grant_r;
          out_status_nxt = res_status_r;
          out_free_nxt   = free_cnt_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_cnt_r  <= CNT_W'(POOL_SIZE);
      row_valid_r <= '0;
      avail_r     <= '1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_cnt_r  <= free_cnt_nxt;
      row_valid_r <= row_valid_nxt;
      avail_r     <= avail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    addr_r       <= addr_nxt;
    bit_r        <= bit_nxt;
    res_grant_r  <= res_grant_nxt;
    res_status_r <= res_status_nxt;
    out_grant_r  <= out_grant_nxt;
    out_status_r <= out_status_nxt;
    out_free_r   <= out_free_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({out_free_r, out_grant_r});
  assign out_tuser  = out_status_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_cnt_r <= CNT_W'(POOL_SIZE))
    else $error("free count above pool size");

  a_we_in_mod: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == S_MOD)
    else $error("free-map write outside modify state");

  a_alloc_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD && kind_r == KIND_ALLOC) |-> word_cur != '0)
    else $error("allocate row has no free slot");

  a_alloc_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD && kind_r == KIND_ALLOC) |=> free_cnt_r == $past(free_cnt_r) - CNT_W'(1))
    else $error("allocate did not take one slot");

  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (avail_r == '0) |-> free_cnt_r == '0)
    else $error("row summary and free count disagree");

endmodule

@@ bench/testbench.sv @@
// testbench for fixed_pool_slot_allocator: directed table then random allocate/free traffic,
// each result checked against its table reply or a built-in model of the free map and free-slot count
// depends on fpsa_pkg and the allocator rtl
`timescale 1ns / 1ps

module testbench;
  import fpsa_pkg::*;

  localparam int SLOTS     = POOL_SIZE_DEF;
  localparam int N_RANDOM  = 1450;
  localparam int HOLD_LEN  = 300;
  localparam int CYCLE_CAP = 150000;

  typedef struct packed {
    logic [GRANT_W-1:0] grant;
    status_t            status;
    logic [CNT_W-1:0]   free_cnt;
  } reply_t;

  typedef struct packed {
    kind_t            kind;
    logic [IDX_W-1:0] slot;
    logic             fixed;
    reply_t           reply;
  } req_row_t;

  localparam reply_t NO_REPLY = '{7'd0, ST_OK, 8'd0};

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IDX_W-1:0] in_tdata = '0;
  logic [KIND_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0] out_tuser;

  // model state
  logic [SLOTS-1:0] pool_free_map;
  logic [CNT_W-1:0] pool_free_count;
  reply_t pending_replies[$];

  int errors = 0;
  int cycle_count = 0;
  int replies_seen = 0;
  int status_seen[4] = '{0, 0, 0, 0};
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  req_row_t dir_rows [25] = '{
    '{KIND_FREE,  8'd0,   1'b1, '{7'd0,  ST_ALREADY_FREE, 8'd16}},
    '{KIND_FREE,  8'd16,  1'b1, '{7'd0,  ST_INVALID,      8'd16}},
    '{KIND_FREE,  8'd255, 1'b1, '{7'd0,  ST_INVALID,      8'd16}},
    '{KIND_FREE,  8'd128, 1'b1, '{7'd0,  ST_INVALID,      8'd16}},
    '{KIND_ALLOC, 8'd255, 1'b1, '{7'd0,  ST_OK, 8'd15}},
    '{KIND_ALLOC, 8'd0,   1'b1, '{7'd1,  ST_OK, 8'd14}},
    '{KIND_ALLOC, 8'd0,   1'b1, '{7'd2,  ST_OK, 8'd13}},
    '{KIND_ALLOC, 8'd0,   1'b1, '{7'd3,  ST_OK, 8'd12}},
    '{KIND_ALLOC, 8'd0,   1'b1, '{7'd4,  ST_OK, 8'd11}},
    '{KIND_ALLOC, 8'd0,   1'b1, '{7'd5,  ST_OK, 8'd10}},
    '{KIND_ALLOC, 8'd0,   1'b1, '{7'd6,  ST_OK, 8'd9}},
    '{KIND_ALLOC, 8'd0,   1'b1, '{7'd7,  ST_OK, 8'd8}},
    '{KIND_ALLOC, 8'd0,   1'b1, '{7'd8,  ST_OK, 8'd7}},
    '{KIND_ALLOC, 8'd0,   1'b1, '{7'd9,  ST_OK, 8'd6}},
    '{KIND_ALLOC, 8'd0,   1'b1, '{7'd10, ST_OK, 8'd5}},
    '{KIND_ALLOC, 8'd0,   1'b1, '{7'd11, ST_OK, 8'd4}},
    '{KIND_ALLOC, 8'd0,   1'b1, '{7'd12, ST_OK, 8'd3}},
    '{KIND_ALLOC, 8'd0,   1'b1, '{7'd13, ST_OK, 8'd2}},
    '{KIND_ALLOC, 8'd0,   1'b1, '{7'd14, ST_OK, 8'd1}},
    '{KIND_ALLOC, 8'd0,   1'b1, '{7'd15, ST_OK, 8'd0}},
    '{KIND_ALLOC, 8'd0,   1'b1, '{7'd0,  ST_EMPTY, 8'd0}},
    '{KIND_FREE,  8'd15,  1'b1, '{7'd0,  ST_OK, 8'd1}},
    '{KIND_FREE,  8'd7,   1'b0, NO_REPLY},
    '{KIND_ALLOC, 8'd0,   1'b0, NO_REPLY},
    '{KIND_ALLOC, 8'd0,   1'b0, NO_REPLY}
  };

  fixed_pool_slot_allocator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic reply_t apply_pool_op(kind_t kind, logic [IDX_W-1:0] slot);
    reply_t r;
    bit found;
    r = '{7'd0, ST_OK, 8'd0};
    found = 1'b0;
    if (kind == KIND_ALLOC) begin
      r.status = ST_EMPTY;
      for (int i = 0; i < SLOTS; i++) begin
        if (!found && pool_free_map[i]) begin
          found = 1'b1;
          pool_free_map[i] = 1'b0;
          pool_free_count = pool_free_count - 1'b1;
          r.grant = GRANT_W'(i);
          r.status = ST_OK;
        end
      end
    end else if (slot >= SLOTS) begin
      r.status = ST_INVALID;
    end else if (pool_free_map[slot]) begin
      r.status = ST_ALREADY_FREE;
    end else begin
      pool_free_map[slot] = 1'b1;
      pool_free_count = pool_free_count + 1'b1;
    end
    r.free_cnt = pool_free_count;
    return r;
  endfunction

  // offer one request, wait for its transaction, then record what should come back
  task automatic send_request(kind_t kind, logic [IDX_W-1:0] slot, logic fixed, reply_t typed);
    reply_t predicted;
    while (!quiet && $urandom_range(0, 99) < 29) begin
      in_tvalid <= 1'b0;
      in_tdata  <= IDX_W'($urandom);
      in_tuser  <= KIND_W'($urandom);
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= slot;
    in_tuser  <= kind;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = apply_pool_op(kind, slot);
    pending_replies.push_back(fixed ? typed : predicted);
  endtask

  function automatic logic [IDX_W-1:0] pick_used_slot();
    int start;
    int s;
    start = $urandom_range(0, SLOTS - 1);
    for (int i = 0; i < SLOTS; i++) begin
      s = (start + i) % SLOTS;
      if (!pool_free_map[s]) return IDX_W'(s);
    end
    return IDX_W'(start);
  endfunction

  initial begin
    int alloc_pct;
    int pick;
    kind_t kind;
    logic [IDX_W-1:0] slot;
    pool_free_map = '1;
    pool_free_count = CNT_W'(SLOTS);
    alloc_pct = 50;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < 25; r++) begin
      send_request(dir_rows[r].kind, dir_rows[r].slot, dir_rows[r].fixed, dir_rows[r].reply);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(0, 3))
          0: alloc_pct = 10;
          1: alloc_pct = 40;
          2: alloc_pct = 65;
          default: alloc_pct = 92;
        endcase
      end
      if (n == 400) hold_req = 1'b1;
      quiet = (n >= 800 && n < 1100);
      pick = $urandom_range(0, 99);
      if (pick < alloc_pct) begin
        kind = KIND_ALLOC;
        slot = IDX_W'($urandom);
      end else begin
        kind = KIND_FREE;
        pick = $urandom_range(0, 99);
        if (pick < 70) slot = pick_used_slot();
        else if (pick < 85) slot = IDX_W'($urandom_range(0, SLOTS - 1));
        else slot = IDX_W'($urandom_range(SLOTS, 255));
      end
      send_request(kind, slot, 1'b0, NO_REPLY);
    end
    in_tvalid <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("%0d requests answered: %0d ok, %0d pool empty, %0d invalid, %0d double free",
             replies_seen, status_seen[ST_OK], status_seen[ST_EMPTY],
             status_seen[ST_INVALID], status_seen[ST_ALREADY_FREE]);
    $display("pool swept between full and empty, one %0d-cycle output hold-off, %0d errors",
             HOLD_LEN, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // receiver: random stalls, one long hold-off, a stall-free window
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_tready <= 1'b0;
      hold_left <= HOLD_LEN - 1;
      hold_done <= 1'b1;
    end else begin
      out_tready <= quiet || ($urandom_range(0, 99) >= 29);
    end
  end

  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[6:0], status_t'(out_tuser), out_tdata[14:7]};
      replies_seen <= replies_seen + 1;
      status_seen[out_tuser] <= status_seen[out_tuser] + 1;
      if (pending_replies.size() == 0) begin
        if (errors < 10) $display("unexpected transaction: grant %0d status %0d free %0d",
                                  got.grant, got.status, got.free_cnt);
        errors <= errors + 1;
      end else begin
        want = pending_replies.pop_front();
        if (got !== want) begin
          if (errors < 10) begin
            $display("mismatch: expected grant %0d status %0d free %0d, got %0d %0d %0d",
                     want.grant, want.status, want.free_cnt,
                     got.grant, got.status, got.free_cnt);
          end
          errors <= errors + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("timeout with %0d results outstanding", pending_replies.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule

@@ filelist.f @@
sv/fpsa_pkg.sv
sv/fpsa_ram.sv
sv/fixed_pool_slot_allocator.sv
bench/testbench.sv
